>>> rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Types, codes and constants shared by the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 64;
    localparam int unsigned IDLE_W     = 32;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned KEY_BYTES  = 4;

    localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = IDLE_W'(1000);

    // register word index (paddr[2])
    localparam logic REG_IDLE_TIMEOUT = 1'b0;

    typedef enum logic [2:0] {
        PH_OPCODE  = 3'd0,
        PH_LEN8    = 3'd1,
        PH_LEN16   = 3'd2,
        PH_LEN64   = 3'd3,
        PH_MASK    = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        EV_HEADER  = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_EMPTY   = 3'd2,
        EV_REJECT  = 3'd3,
        EV_TIMEOUT = 3'd4,
        EV_NONE    = 3'd5
    } t_event;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    typedef struct packed {
        t_event             event_kind;
        logic [BYTE_W-1:0]  payload_byte;
        logic [3:0]         frame_opcode;
        logic               frame_fin;
        logic               last_of_frame;
    } t_result;

    function automatic logic opcode_known(input logic [3:0] op);
        return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BIN) ||
               (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

>>> rtl/wsd_ifs.sv
// ----------------------------------------------------------------------------
// wsd_in_if / wsd_out_if
// Valid/ready stream channels for received bytes and parser events.
// ----------------------------------------------------------------------------
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface wsd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       frame_fin;
    logic       last_of_frame;

    modport source (output valid, output event_kind, output payload_byte,
                    output frame_opcode, output frame_fin, output last_of_frame,
                    input ready);
    modport sink   (input valid, input event_kind, input payload_byte,
                    input frame_opcode, input frame_fin, input last_of_frame,
                    output ready);
endinterface

>>> rtl/websocket_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Receive-side WebSocket frame parser: header, length, mask key, unmasking.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  i_rx      in   action (byte / tick), rx_byte
//  o_ev      out  event_kind, payload_byte, frame_opcode, frame_fin,
//                 last_of_frame
//  APB       in   idle_timeout_ticks at address 0
//
// One result beat per input beat; a beat can enter every cycle while the
// result register is free or being drained. Path: input register, then parser
// step into the result register, which holds while o_ev.ready is low.
// Synchronous active-low reset; the timeout register resets to 1000.
// A stall on o_ev blocks i_rx only once both registers are full.
module websocket_frame_deframer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    wsd_in_if.sink                            i_rx,
    wsd_out_if.source                         o_ev,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wsd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [wsd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [wsd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import wsd_pkg::*;

    logic              r_in_vld;
    logic              r_in_action;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_vld;
    t_result           r_out;
    t_result           w_result;
    logic              w_adv;
    logic [IDLE_W-1:0] w_idle_timeout;

    wsd_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_idle_timeout (w_idle_timeout)
    );

    wsd_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_adv),
        .i_action       (r_in_action),
        .i_rx_byte      (r_in_byte),
        .i_idle_timeout (w_idle_timeout),
        .o_result       (w_result)
    );

    // advance when the result slot is free or being drained
    assign w_adv      = r_in_vld && (!r_out_vld || o_ev.ready);
    assign i_rx.ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_vld <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_action <= i_rx.action;
            r_in_byte   <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_ev.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_ev.valid         = r_out_vld;
    assign o_ev.event_kind    = r_out.event_kind;
    assign o_ev.payload_byte  = r_out.payload_byte;
    assign o_ev.frame_opcode  = r_out.frame_opcode;
    assign o_ev.frame_fin     = r_out.frame_fin;
    assign o_ev.last_of_frame = r_out.last_of_frame;

endmodule

>>> rtl/wsd_apb_regs.sv
// ----------------------------------------------------------------------------
// wsd_apb_regs
// APB register file holding the idle timeout in ticks.
// ----------------------------------------------------------------------------
module wsd_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wsd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [wsd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [wsd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [wsd_pkg::IDLE_W-1:0]        o_idle_timeout
);
    import wsd_pkg::*;

    logic [IDLE_W-1:0] r_idle_timeout;
    logic              w_sel_timeout;

    assign w_sel_timeout = (paddr[2] == REG_IDLE_TIMEOUT);
    assign pready        = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_timeout <= IDLE_TIMEOUT_RST;
        end else if (psel && penable && pwrite && pready && w_sel_timeout) begin
            r_idle_timeout <= pwdata[IDLE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_timeout) begin
            prdata[IDLE_W-1:0] = r_idle_timeout;
        end
    end

    assign o_idle_timeout = r_idle_timeout;

endmodule

>>> rtl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header state machine, unmasking and idle timeout; one step per beat.
// ----------------------------------------------------------------------------
module wsd_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_action,
    input  logic [wsd_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic [wsd_pkg::IDLE_W-1:0]    i_idle_timeout,
    output wsd_pkg::t_result              o_result
);
    import wsd_pkg::*;

    t_phase            r_phase, n_phase;
    logic              r_fin, n_fin;
    logic [3:0]        r_opcode, n_opcode;
    logic              r_mask_on, n_mask_on;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [2:0]        r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_key [KEY_BYTES];
    logic              n_key_we;
    logic [IDLE_W-1:0] r_idle, n_idle;

    logic              w_tick;
    logic [IDLE_W-1:0] w_idle_inc;
    logic              w_timeout;
    logic              w_hdr_ok;
    logic [6:0]        w_len7;
    logic [LEN_W-1:0]  w_len_shift;
    logic              w_ext_done;
    logic              w_ext_zero;
    logic              w_len7_zero;

    assign w_tick      = (i_action == ACT_TICK);
    assign w_idle_inc  = (&r_idle) ? r_idle : r_idle + IDLE_W'(1);
    assign w_timeout   = (r_phase != PH_OPCODE) && (w_idle_inc > i_idle_timeout);
    assign w_hdr_ok    = (i_rx_byte[6:4] == 3'b000) && opcode_known(i_rx_byte[3:0]);
    assign w_len7      = i_rx_byte[6:0];
    assign w_len7_zero = (w_len7 == 7'd0);
    assign w_len_shift = {r_len[LEN_W-BYTE_W-1:0], i_rx_byte};
    assign w_ext_zero  = (w_len_shift == '0);
    assign w_ext_done  = (r_phase == PH_LEN16) ? (r_cnt == 3'd1) : (r_cnt == 3'd7);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_tick) begin
            if (w_timeout) begin
                n_phase = PH_OPCODE;
            end
        end else begin
            unique case (r_phase)
                PH_OPCODE: begin
                    if (w_hdr_ok) begin
                        n_phase = PH_LEN8;
                    end
                end
                PH_LEN8: begin
                    priority if (w_len7 == LEN_EXT16) begin
                        n_phase = PH_LEN16;
                    end else if (w_len7 == LEN_EXT64) begin
                        n_phase = PH_LEN64;
                    end else if (i_rx_byte[7]) begin
                        n_phase = PH_MASK;
                    end else if (w_len7_zero) begin
                        n_phase = PH_OPCODE;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_LEN16, PH_LEN64: begin
                    if (w_ext_done) begin
                        priority if (r_mask_on) begin
                            n_phase = PH_MASK;
                        end else if (w_ext_zero) begin
                            n_phase = PH_OPCODE;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_MASK: begin
                    if (r_cnt == 3'd3) begin
                        n_phase = (r_len == '0) ? PH_OPCODE : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_len == LEN_W'(1)) begin
                        n_phase = PH_OPCODE;
                    end
                end
                default: n_phase = PH_OPCODE;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_fin     = r_fin;
        n_opcode  = r_opcode;
        n_mask_on = r_mask_on;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_key_we  = 1'b0;
        n_idle    = r_idle;
        o_result.event_kind    = EV_NONE;
        o_result.payload_byte  = '0;
        o_result.last_of_frame = 1'b0;
        if (w_tick) begin
            if (r_phase != PH_OPCODE) begin
                n_idle = w_timeout ? '0 : w_idle_inc;
                if (w_timeout) begin
                    o_result.event_kind = EV_TIMEOUT;
                end
            end
        end else begin
            n_idle = '0;
            unique case (r_phase)
                PH_OPCODE: begin
                    if (w_hdr_ok) begin
                        n_fin               = i_rx_byte[7];
                        n_opcode            = i_rx_byte[3:0];
                        o_result.event_kind = EV_HEADER;
                    end else begin
                        o_result.event_kind = EV_REJECT;
                    end
                end
                PH_LEN8: begin
                    n_mask_on = i_rx_byte[7];
                    n_cnt     = '0;
                    if ((w_len7 == LEN_EXT16) || (w_len7 == LEN_EXT64)) begin
                        n_len = '0;
                    end else begin
                        n_len = LEN_W'(w_len7);
                    end
                    o_result.event_kind =
                        (!i_rx_byte[7] && w_len7_zero) ? EV_EMPTY : EV_HEADER;
                end
                PH_LEN16, PH_LEN64: begin
                    n_len = w_len_shift;
                    if (w_ext_done) begin
                        n_cnt = '0;
                        o_result.event_kind =
                            (!r_mask_on && w_ext_zero) ? EV_EMPTY : EV_HEADER;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                        o_result.event_kind = EV_HEADER;
                    end
                end
                PH_MASK: begin
                    n_key_we = 1'b1;
                    if (r_cnt == 3'd3) begin
                        n_cnt = '0;
                        o_result.event_kind = (r_len == '0) ? EV_EMPTY : EV_HEADER;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                        o_result.event_kind = EV_HEADER;
                    end
                end
                PH_PAYLOAD: begin
                    // count the remaining length down; low index bits pick the key byte
                    n_len = r_len - LEN_W'(1);
                    n_cnt = r_cnt + 3'd1;
                    o_result.event_kind    = EV_PAYLOAD;
                    o_result.payload_byte  =
                        r_mask_on ? (i_rx_byte ^ r_key[r_cnt[1:0]]) : i_rx_byte;
                    o_result.last_of_frame = (r_len == LEN_W'(1));
                end
                default: o_result.event_kind = EV_NONE;
            endcase
        end
        o_result.frame_opcode = n_opcode;
        o_result.frame_fin    = n_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OPCODE;
            r_fin     <= 1'b0;
            r_opcode  <= '0;
            r_mask_on <= 1'b0;
            r_len     <= '0;
            r_cnt     <= '0;
            r_idle    <= '0;
            for (int k = 0; k < KEY_BYTES; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_fin     <= n_fin;
            r_opcode  <= n_opcode;
            r_mask_on <= n_mask_on;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
            r_idle    <= n_idle;
            if (n_key_we) begin
                r_key[r_cnt[1:0]] <= i_rx_byte;
            end
        end
    end

endmodule
